>>> rtl/core/dcr_pkg.sv
package dcr_pkg;

    // Defaults for the top-level parameters
    localparam int CHUNK_BYTES_DEF = 1024;
    localparam int MAX_CHUNKS_DEF  = 64;

    // Datagram header layout (little-endian)
    localparam int HDR_LEN     = 16;
    localparam int HDR_MAGIC   = 0;
    localparam int HDR_FRAME   = 4;
    localparam int HDR_IDX     = 8;
    localparam int HDR_COUNT   = 10;
    localparam int HDR_SIZE    = 12;

    // A chunk size that passes the short check fits CHUNK_BYTES, at most 16383 in SIZE_W bits
    localparam int SIZE_W      = 14;
    localparam int LEN_W       = 17;
    localparam int EPOCH_W     = 8;

    localparam int OPQ_DEPTH   = 4;
    localparam int RESQ_DEPTH  = 4;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_RUNT         = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_SHORT        = 3'd3,
        ST_OUT_OF_RANGE = 3'd4,
        ST_DUPLICATE    = 3'd5,
        ST_TOO_MANY     = 3'd6
    } t_status;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // Work handed from the front end to the back end, one per beat that
    // yields a payload write, a datagram end, or both
    typedef struct packed {
        logic              has_wr;
        logic [15:0]       wr_addr;
        logic [7:0]        wr_data;
        logic              has_st;
        t_status           pre_code;
        logic [15:0]       idx;
        logic [31:0]       frame;
        logic [15:0]       count;
        logic [SIZE_W-1:0] size;
    } t_op;

    typedef struct packed {
        t_kind            kind;
        logic [15:0]      addr;
        logic [7:0]       data;
        t_status          code;
        logic [15:0]      chunk;
        logic [31:0]      frame;
        logic             complete;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_res;

endpackage

>>> rtl/core/datagram_chunk_reassembler.sv
// Datagram chunk reassembler.
// Input channel: one received byte per beat (i_rx_byte, i_end_of_datagram),
// taken while push is high and full is low. Each datagram starts with a
// 16-byte little-endian header (magic, frame, chunk index, count, size).
// Result channel: a queue; the oldest result sits on the o_ ports while
// empty is low and leaves when pop is high. Payload bytes give a write
// result at index*CHUNK_BYTES+offset; the last byte of a datagram gives a
// status result after its write. last_of_run marks the final result of a beat.
// Config: i_cfg_we/i_cfg_wdata load the expected magic word; write it idle.
// Throughput: one beat per cycle while results are drained. A datagram end
// whose header passes the early checks takes an extra back-end state for
// the chunk-map read; a beat with both a write and a status pushes its
// write, then its status. The op queue between front and back soaks this up.
// Path: a write result passes through the op queue and the result queue;
// a checked status also waits on the registered map read in S_EVAL.
// Reset: the chunk map is swept, full held high. The map is tagged by
// frame epoch; after 255 frame clears a further sweep runs and the back
// end pauses meanwhile.
// A stalled receiver fills the result queue, then the op queue, then full.
module datagram_chunk_reassembler #(
    parameter int CHUNK_BYTES = dcr_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_CHUNKS  = dcr_pkg::MAX_CHUNKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_datagram,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [2:0]  o_status_code,
    output logic [15:0] o_chunk_number,
    output logic [31:0] o_frame_id,
    output logic        o_frame_complete,
    output logic [16:0] o_frame_length,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    import dcr_pkg::*;

    logic [31:0] r_magic;
    logic        accept;
    logic        op_push;
    t_op         op_in;
    t_op         op_head;
    logic        opq_full;
    logic        opq_empty;
    logic        op_pop;
    logic        sweeping;
    logic        res_push;
    t_res        res_in;
    t_res        res_head;
    logic        resq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_wdata;
        end
    end

    // held full while the map is being swept
    assign full   = opq_full || sweeping;
    assign accept = push && !full;

    dcr_front #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_CHUNKS  (MAX_CHUNKS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_eod      (i_end_of_datagram),
        .i_magic    (r_magic),
        .o_op_valid (op_push),
        .o_op       (op_in)
    );

    dcr_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_wdata (op_in),
        .o_full  (opq_full),
        .i_pop   (op_pop),
        .o_rdata (op_head),
        .o_empty (opq_empty)
    );

    dcr_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!opq_empty),
        .i_op       (op_head),
        .o_op_pop   (op_pop),
        .i_res_full (resq_full),
        .o_res_push (res_push),
        .o_res      (res_in),
        .o_sweeping (sweeping)
    );

    dcr_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_rdata (res_head),
        .o_empty (empty)
    );

    assign o_result_kind    = res_head.kind;
    assign o_write_address  = res_head.addr;
    assign o_write_data     = res_head.data;
    assign o_status_code    = res_head.code;
    assign o_chunk_number   = res_head.chunk;
    assign o_frame_id       = res_head.frame;
    assign o_frame_complete = res_head.complete;
    assign o_frame_length   = res_head.length;
    assign o_last_of_run    = res_head.last;

endmodule

>>> rtl/core/dcr_ram.sv
module dcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/dcr_fifo.sv
module dcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/dcr_front.sv
module dcr_front #(
    parameter int CHUNK_BYTES = dcr_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_CHUNKS  = dcr_pkg::MAX_CHUNKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_rx_byte,
    input  logic         i_eod,
    input  logic [31:0]  i_magic,
    output logic         o_op_valid,
    output dcr_pkg::t_op o_op
);

    import dcr_pkg::*;

    localparam int POS_W   = $clog2(CHUNK_BYTES + HDR_LEN + 1);
    localparam int POS_MAX = CHUNK_BYTES + HDR_LEN;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_hdr [HDR_LEN];
    logic [7:0]       n_hdr [HDR_LEN];
    logic [15:0]      r_base;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] pay_len;
    logic             has_wr;
    logic [31:0]      magic;
    logic [31:0]      frame;
    logic [15:0]      idx;
    logic [15:0]      count;
    logic [31:0]      size;
    logic             runt;

    always_comb begin
        n_hdr = r_hdr;
        if (r_pos < POS_W'(HDR_LEN)) begin
            n_hdr[r_pos[3:0]] = i_rx_byte;
        end
        has_wr  = (r_pos >= POS_W'(HDR_LEN)) && (r_pos < POS_W'(POS_MAX));
        pos_inc = (r_pos < POS_W'(POS_MAX)) ? r_pos + 1'b1 : r_pos;
        pay_len = pos_inc - POS_W'(HDR_LEN);
        n_pos   = i_eod ? '0 : pos_inc;

        magic = {n_hdr[HDR_MAGIC+3], n_hdr[HDR_MAGIC+2], n_hdr[HDR_MAGIC+1], n_hdr[HDR_MAGIC]};
        frame = {n_hdr[HDR_FRAME+3], n_hdr[HDR_FRAME+2], n_hdr[HDR_FRAME+1], n_hdr[HDR_FRAME]};
        idx   = {n_hdr[HDR_IDX+1], n_hdr[HDR_IDX]};
        count = {n_hdr[HDR_COUNT+1], n_hdr[HDR_COUNT]};
        size  = {n_hdr[HDR_SIZE+3], n_hdr[HDR_SIZE+2], n_hdr[HDR_SIZE+1], n_hdr[HDR_SIZE]};
        runt  = pos_inc < POS_W'(HDR_LEN);

        o_op          = '0;
        o_op.has_wr   = has_wr;
        o_op.wr_addr  = r_base + 16'(r_pos - POS_W'(HDR_LEN));
        o_op.wr_data  = i_rx_byte;
        o_op.has_st   = i_eod;
        o_op.idx      = runt ? '0 : idx;
        o_op.frame    = runt ? '0 : frame;
        o_op.count    = count;
        o_op.size     = size[SIZE_W-1:0];
        if (runt) begin
            o_op.pre_code = ST_RUNT;
        end else if (magic != i_magic) begin
            o_op.pre_code = ST_BAD_MAGIC;
        end else if (size > 32'(pay_len)) begin
            o_op.pre_code = ST_SHORT;
        end else if (count > 16'(MAX_CHUNKS)) begin
            o_op.pre_code = ST_TOO_MANY;
        end else begin
            o_op.pre_code = ST_OK;
        end
    end

    assign o_op_valid = i_accept && (has_wr || i_eod);

    // chunk base address, formed once the index bytes are in
    always_ff @(posedge i_clk) begin
        if (i_accept && (r_pos == POS_W'(HDR_IDX + 2))) begin
            r_base <= 16'(32'({r_hdr[HDR_IDX+1], r_hdr[HDR_IDX]}) * 32'(CHUNK_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
        end
    end

endmodule

>>> rtl/core/dcr_back.sv
module dcr_back #(
    parameter int MAX_CHUNKS = dcr_pkg::MAX_CHUNKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  dcr_pkg::t_op  i_op,
    output logic          o_op_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output dcr_pkg::t_res o_res,
    output logic          o_sweeping
);

    import dcr_pkg::*;

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_EVAL  = 3'b010,
        S_SWEEP = 3'b100
    } t_bstate;

    t_bstate            r_state, n_state;
    logic               r_wr_done, n_wr_done;
    logic [31:0]        r_cur_frame, n_cur_frame;
    logic [CNT_W-1:0]   r_exp, n_exp;
    logic [CNT_W-1:0]   r_rcount, n_rcount;
    logic [LEN_W-1:0]   r_total, n_total;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [IDX_W-1:0]   r_sw, n_sw;
    logic               r_mark_v, n_mark_v;
    logic [IDX_W-1:0]   r_mark_idx, n_mark_idx;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;
    logic [EPOCH_W-1:0] ram_rdata;

    logic               new_frame;
    logic [CNT_W-1:0]   exp_eff;
    logic [CNT_W-1:0]   rc_base;
    logic [CNT_W-1:0]   rc_inc;
    logic [LEN_W-1:0]   tot_base;
    logic [LEN_W:0]     tot_sum;
    logic [LEN_W-1:0]   tot_sat;
    logic               seen;
    logic               oor;
    logic               take;
    logic               complete;
    logic               bump;
    logic               wrap;
    logic               mark;
    logic [EPOCH_W-1:0] epoch_eval;

    dcr_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_CHUNKS),
        .AW    (IDX_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_op.idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // chunk check against the epoch-tagged map
    always_comb begin
        new_frame = i_op.frame != r_cur_frame;
        exp_eff   = new_frame ? CNT_W'(i_op.count) : r_exp;
        rc_base   = new_frame ? '0 : r_rcount;
        tot_base  = new_frame ? '0 : r_total;
        seen      = !new_frame && (ram_rdata == r_epoch);
        oor       = i_op.idx >= 16'(exp_eff);
        take      = !oor && !seen;
        rc_inc    = rc_base + 1'b1;
        tot_sum   = {1'b0, tot_base} + (LEN_W + 1)'(i_op.size);
        tot_sat   = tot_sum[LEN_W] ? '1 : tot_sum[LEN_W-1:0];
        complete  = take && (rc_inc >= exp_eff);
        bump      = new_frame || complete;
        wrap      = bump && (r_epoch == '1);
        mark      = take && !complete;
        if (!bump) begin
            epoch_eval = r_epoch;
        end else if (wrap) begin
            epoch_eval = EPOCH_W'(1);
        end else begin
            epoch_eval = r_epoch + 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wr_done   = r_wr_done;
        n_cur_frame = r_cur_frame;
        n_exp       = r_exp;
        n_rcount    = r_rcount;
        n_total     = r_total;
        n_epoch     = r_epoch;
        n_sw        = r_sw;
        n_mark_v    = r_mark_v;
        n_mark_idx  = r_mark_idx;
        o_op_pop    = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        ram_we      = 1'b0;
        ram_waddr   = i_op.idx[IDX_W-1:0];
        ram_wdata   = epoch_eval;

        case (r_state)
            S_RUN: begin
                if (i_op_valid) begin
                    if (i_op.has_wr && !r_wr_done) begin
                        o_res.kind = KIND_WRITE;
                        o_res.addr = i_op.wr_addr;
                        o_res.data = i_op.wr_data;
                        o_res.last = !i_op.has_st;
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            if (i_op.has_st) begin
                                n_wr_done = 1'b1;
                            end else begin
                                o_op_pop = 1'b1;
                            end
                        end
                    end else if (i_op.pre_code != ST_OK) begin
                        o_res.kind  = KIND_STATUS;
                        o_res.code  = i_op.pre_code;
                        o_res.chunk = i_op.idx;
                        o_res.frame = i_op.frame;
                        o_res.last  = 1'b1;
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_op_pop   = 1'b1;
                            n_wr_done  = 1'b0;
                        end
                    end else begin
                        // map read issued this edge
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_res.kind     = KIND_STATUS;
                o_res.chunk    = i_op.idx;
                o_res.frame    = i_op.frame;
                o_res.complete = complete;
                o_res.length   = complete ? tot_sat : '0;
                o_res.last     = 1'b1;
                if (oor) begin
                    o_res.code = ST_OUT_OF_RANGE;
                end else if (seen) begin
                    o_res.code = ST_DUPLICATE;
                end else begin
                    o_res.code = ST_OK;
                end
                if (!i_res_full) begin
                    o_res_push  = 1'b1;
                    o_op_pop    = 1'b1;
                    n_wr_done   = 1'b0;
                    n_cur_frame = i_op.frame;
                    n_epoch     = epoch_eval;
                    if (complete) begin
                        n_exp    = '0;
                        n_rcount = '0;
                        n_total  = '0;
                    end else begin
                        n_exp    = exp_eff;
                        n_rcount = take ? rc_inc : rc_base;
                        n_total  = take ? tot_sat : tot_base;
                    end
                    if (wrap) begin
                        n_state    = S_SWEEP;
                        n_sw       = '0;
                        n_mark_v   = mark;
                        n_mark_idx = i_op.idx[IDX_W-1:0];
                    end else begin
                        n_state = S_RUN;
                        ram_we  = mark;
                    end
                end
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sw;
                ram_wdata = (r_mark_v && (r_sw == r_mark_idx)) ? EPOCH_W'(1) : '0;
                n_sw      = r_sw + 1'b1;
                if (r_sw == IDX_W'(MAX_CHUNKS - 1)) begin
                    n_sw     = '0;
                    n_mark_v = 1'b0;
                    n_state  = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    assign o_sweeping = (r_state == S_SWEEP);

    always_ff @(posedge i_clk) begin
        r_mark_idx <= n_mark_idx;
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_wr_done   <= 1'b0;
            r_cur_frame <= '0;
            r_exp       <= '0;
            r_rcount    <= '0;
            r_total     <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_sw        <= '0;
            r_mark_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_done   <= n_wr_done;
            r_cur_frame <= n_cur_frame;
            r_exp       <= n_exp;
            r_rcount    <= n_rcount;
            r_total     <= n_total;
            r_epoch     <= n_epoch;
            r_sw        <= n_sw;
            r_mark_v    <= n_mark_v;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res_push && i_res_full))
        else $error("result pushed into a full queue");

    a_eval_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> i_op_valid)
        else $error("chunk check without a pending op");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch tag zero would alias cleared entries");

    a_count_below_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rcount < r_exp) || (r_rcount == '0))
        else $error("received count reached expected without completion");

    a_sweep_then_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_sw == IDX_W'(MAX_CHUNKS - 1)) |=> (r_state == S_RUN))
        else $error("sweep did not finish");

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcr_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          RST_CYCLES  = 6;
    // The back end trails its beat; allow for a full map sweep too
    localparam int          SETTLE      = MAX_CHUNKS_DEF + 8;
    localparam int          TAIL        = 20;
    localparam int unsigned DRAIN_LIMIT = 50000;
    localparam longint      TIMEOUT_NS  = 64'd5_000_000;
    localparam int unsigned TOTAL_MAX   = 131071;

    // ---------------------------------------------------------------------
    // DUT signals, inputs driven to known values from time zero
    // ---------------------------------------------------------------------
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte         = '0;
    logic        i_end_of_datagram = 1'b0;
    logic        empty;
    logic        pop               = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_write_address;
    logic [7:0]  o_write_data;
    logic [2:0]  o_status_code;
    logic [15:0] o_chunk_number;
    logic [31:0] o_frame_id;
    logic        o_frame_complete;
    logic [16:0] o_frame_length;
    logic        o_last_of_run;
    logic        i_cfg_we          = 1'b0;
    logic [31:0] i_cfg_wdata       = '0;

    datagram_chunk_reassembler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data),
        .o_status_code     (o_status_code),
        .o_chunk_number    (o_chunk_number),
        .o_frame_id        (o_frame_id),
        .o_frame_complete  (o_frame_complete),
        .o_frame_length    (o_frame_length),
        .o_last_of_run     (o_last_of_run),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: our own copy of the reassembly state after reset
    // ---------------------------------------------------------------------
    logic [31:0]             magic_reg   = '0;
    logic [7:0]              hdr_bytes [HDR_LEN] = '{default: 8'h00};
    int unsigned             rx_pos      = 0;
    logic [31:0]             cur_frame   = '0;
    int unsigned             exp_chunks  = 0;   // zero: no frame active
    bit [MAX_CHUNKS_DEF-1:0] got_map     = '0;
    int unsigned             got_chunks  = 0;
    int unsigned             byte_total  = 0;

    t_res        pending_results [$];   // expected results, oldest first
    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;

    // Sender and receiver pacing, adjusted by the tests
    int unsigned tx_gap_max    = 3;
    int unsigned tx_burst_left = 0;
    bit          rx_stalls     = 1'b1;
    int unsigned rx_hold       = 0;
    int unsigned rx_run        = 0;
    bit          rx_on         = 1'b0;

    logic [7:0]  dgram [$];             // datagram being assembled for sending

    function automatic void clear_frame_map();
        got_map    = '0;
        got_chunks = 0;
        byte_total = 0;
    endfunction

    // Work out what one accepted beat should produce: a payload write for a
    // kept payload byte, then a status when the beat ends the datagram.
    task automatic reassemble_beat(input logic [7:0] b, input logic eod);
        t_res        r;
        int unsigned len;
        int unsigned idx;
        int unsigned count;
        logic [31:0] magic;
        logic [31:0] frame;
        logic [31:0] size;
        r = '0;
        if (rx_pos < HDR_LEN) begin
            hdr_bytes[rx_pos] = b;
        end else if (rx_pos < CHUNK_BYTES_DEF + HDR_LEN) begin
            idx    = {hdr_bytes[HDR_IDX+1], hdr_bytes[HDR_IDX]};
            r.kind = KIND_WRITE;
            r.addr = 16'(idx * CHUNK_BYTES_DEF + rx_pos - HDR_LEN);
            r.data = b;
            r.last = !eod;
            pending_results.push_back(r);
        end
        // bytes past a full chunk are dropped and do not move the position
        if (rx_pos < CHUNK_BYTES_DEF + HDR_LEN)
            rx_pos++;
        if (!eod)
            return;

        len    = rx_pos;
        rx_pos = 0;
        r      = '0;
        r.kind = KIND_STATUS;
        r.last = 1'b1;
        if (len < HDR_LEN) begin
            r.code = ST_RUNT;
            pending_results.push_back(r);
            return;
        end
        magic = {hdr_bytes[HDR_MAGIC+3], hdr_bytes[HDR_MAGIC+2],
                 hdr_bytes[HDR_MAGIC+1], hdr_bytes[HDR_MAGIC]};
        frame = {hdr_bytes[HDR_FRAME+3], hdr_bytes[HDR_FRAME+2],
                 hdr_bytes[HDR_FRAME+1], hdr_bytes[HDR_FRAME]};
        idx   = {hdr_bytes[HDR_IDX+1], hdr_bytes[HDR_IDX]};
        count = {hdr_bytes[HDR_COUNT+1], hdr_bytes[HDR_COUNT]};
        size  = {hdr_bytes[HDR_SIZE+3], hdr_bytes[HDR_SIZE+2],
                 hdr_bytes[HDR_SIZE+1], hdr_bytes[HDR_SIZE]};
        r.chunk = idx[15:0];
        r.frame = frame;

        if (magic != magic_reg) begin
            r.code = ST_BAD_MAGIC;
        end else if (size > len - HDR_LEN) begin
            r.code = ST_SHORT;
        end else if (count > MAX_CHUNKS_DEF) begin
            // dropped outright, frame state untouched
            r.code = ST_TOO_MANY;
        end else begin
            if (frame != cur_frame) begin
                cur_frame  = frame;
                exp_chunks = count;
                clear_frame_map();
            end
            if (idx >= exp_chunks || idx >= MAX_CHUNKS_DEF) begin
                r.code = ST_OUT_OF_RANGE;
            end else if (got_map[idx]) begin
                r.code = ST_DUPLICATE;
            end else begin
                r.code       = ST_OK;
                got_map[idx] = 1'b1;
                got_chunks++;
                byte_total += size;
                if (byte_total > TOTAL_MAX)
                    byte_total = TOTAL_MAX;
                if (got_chunks >= exp_chunks) begin
                    r.complete = 1'b1;
                    r.length   = byte_total[LEN_W-1:0];
                    exp_chunks = 0;
                    clear_frame_map();
                end
            end
        end
        pending_results.push_back(r);
    endtask

    // ---------------------------------------------------------------------
    // Result checking, one beat per rising edge with pop high and empty low
    // ---------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        t_res want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: kind %0d addr 0x%0h code %0d",
                   o_result_kind, o_write_address, o_status_code);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("result_kind",    want.kind,     o_result_kind);
            check_field("write_address",  want.addr,     o_write_address);
            check_field("write_data",     want.data,     o_write_data);
            check_field("status_code",    want.code,     o_status_code);
            check_field("chunk_number",   want.chunk,    o_chunk_number);
            check_field("frame_id",       want.frame,    o_frame_id);
            check_field("frame_complete", want.complete, o_frame_complete);
            check_field("frame_length",   want.length,   o_frame_length);
            check_field("last_of_run",    want.last,     o_last_of_run);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop === 1'b1 && empty === 1'b0)
            check_result();
    end

    // Receiver: a long hold-off when a test asks for one, otherwise either
    // always ready or alternating random ready/stall runs.
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else if (!rx_stalls) begin
            pop <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_on  = !rx_on;
                rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_run--;
            pop <= rx_on;
        end
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------
    // One beat, sent within a burst; a random gap opens each new burst.
    // push is left high after acceptance so back-to-back beats never dip.
    task automatic send_beat(input logic [7:0] b, input logic eod);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            tx_burst_left = $urandom_range(1, 16);
        end
        tx_burst_left--;
        @(negedge i_clk);
        push              <= 1'b1;
        i_rx_byte         <= b;
        i_end_of_datagram <= eod;
        @(posedge i_clk);
        while (full !== 1'b0)
            @(posedge i_clk);
        bytes_sent++;
        reassemble_beat(b, eod);
    endtask

    task automatic send_dgram();
        foreach (dgram[i])
            send_beat(dgram[i], i == dgram.size() - 1);
    endtask

    // Header-led datagram with the given header fields and payload length
    task automatic send_chunk(input logic [31:0] magic, input logic [31:0] frame,
                              input logic [15:0] idx, input logic [15:0] count,
                              input logic [31:0] size, input int unsigned payload);
        dgram = {};
        for (int i = 0; i < 4; i++)
            dgram.push_back(magic[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            dgram.push_back(frame[8*i +: 8]);
        for (int i = 0; i < 2; i++)
            dgram.push_back(idx[8*i +: 8]);
        for (int i = 0; i < 2; i++)
            dgram.push_back(count[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            dgram.push_back(size[8*i +: 8]);
        repeat (payload)
            dgram.push_back(8'($urandom));
        send_dgram();
    endtask

    // Datagram of n random bytes; under 16 it is a runt
    task automatic send_noise(input int unsigned n);
        dgram = {};
        repeat (n)
            dgram.push_back(8'($urandom));
        send_dgram();
    endtask

    // Stop offering beats and wait for every expected result
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        push          <= 1'b0;
        tx_burst_left  = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
            pending_results.delete();
        end
    endtask

    // Magic register write, only with the block idle
    task automatic set_magic(input logic [31:0] value);
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        magic_reg    = value;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Magic still at its reset value; frame 0 is current but no frame is active
    task automatic test_reset_state();
        send_noise(1);
        send_noise(HDR_LEN - 1);
        send_chunk(32'h0, 32'h0, 16'd0, 16'd1, 32'd2, 2);
        send_chunk(32'h0, 32'h0, 16'd0, 16'd0, 32'd0, 0);   // header only
    endtask

    // Runt, bad magic, short and too-many checks, in their order of priority
    task automatic test_header_checks();
        set_magic(32'hFFFF_FFFF);
        send_chunk(32'h0, 32'd1, 16'd0, 16'd1, 32'd0, 3);
        send_chunk(32'h7FFF_FFFF, 32'd1, 16'd0, 16'd65, 32'd9, 1);  // bad magic wins
        send_chunk(magic_reg, 32'd1, 16'd0, 16'd1, 32'd5, 4);
        send_chunk(magic_reg, 32'd1, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 1); // short wins
        send_chunk(magic_reg, 32'd1, 16'd0, 16'(MAX_CHUNKS_DEF + 1), 32'd0, 2);
        send_chunk(magic_reg, 32'd1, 16'd0, 16'hFFFF, 32'd0, 0);
        send_noise(HDR_LEN - 1);
    endtask

    // New frame, out of range, duplicate and completion
    task automatic test_frame_tracking();
        send_chunk(magic_reg, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0, 1);  // count 0
        send_chunk(magic_reg, 32'h1234_5678, 16'd0, 16'd3, 32'd3, 3);
        send_chunk(magic_reg, 32'h1234_5678, 16'd0, 16'd3, 32'd3, 3);  // duplicate
        send_chunk(magic_reg, 32'h1234_5678, 16'd3, 16'd3, 32'd0, 1);
        send_chunk(magic_reg, 32'h1234_5678, 16'hFFFF, 16'd3, 32'd0, 2); // address wraps
        // too many chunks must leave the frame untouched
        send_chunk(magic_reg, 32'h1234_5678, 16'd1, 16'd65, 32'd0, 0);
        send_chunk(magic_reg, 32'h1234_5678, 16'd2, 16'd9, 32'd0, 2);
        send_chunk(magic_reg, 32'h1234_5678, 16'd1, 16'd3, 32'd4, 4);  // completes
        send_chunk(magic_reg, 32'h1234_5678, 16'd0, 16'd3, 32'd1, 1);  // after completion
        send_chunk(magic_reg, 32'd7, 16'd63, 16'(MAX_CHUNKS_DEF), 32'd1, 1);
        send_chunk(magic_reg, 32'd7, 16'd64, 16'(MAX_CHUNKS_DEF), 32'd0, 0);
        send_chunk(magic_reg, 32'd8, 16'd1, 16'd2, 32'd2, 3);
        send_chunk(magic_reg, 32'd7, 16'd0, 16'd1, 32'd6, 6);          // frame 7 anew
    endtask

    // Bytes beyond a full chunk are ignored
    task automatic test_long_datagram();
        set_magic($urandom);
        send_chunk(magic_reg, 32'd9, 16'd63, 16'd1, 32'd0, 1);
        send_chunk(magic_reg, 32'd9, 16'd0, 16'd1, 32'(CHUNK_BYTES_DEF),
                   CHUNK_BYTES_DEF + 8);
    endtask

    // Receiver holds off while the sender keeps offering: queues fill, full rises
    task automatic test_back_pressure();
        tx_gap_max = 0;
        rx_hold    = 120;
        send_chunk(magic_reg, 32'd10, 16'd0, 16'd1, 32'd64, 64);
        drain_results();
        tx_gap_max = 5;
        rx_hold    = 120;
        send_chunk(magic_reg, 32'd11, 16'd1, 16'd2, 32'd30, 30);
        send_chunk(magic_reg, 32'd11, 16'd0, 16'd2, 32'd30, 31);
        tx_gap_max = 3;
    endtask

    // Mostly well-formed chunks of a few live frames, with broken ones and noise
    task automatic test_random_stream();
        logic [31:0] live_frame;
        logic [15:0] live_count;
        logic [15:0] idx;
        logic [31:0] size;
        int unsigned pick;
        int unsigned stop_at;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       set_magic($urandom);
                1:       set_magic(32'hA5A5_5A5A);
                default: set_magic(32'h8000_0001);
            endcase
            tx_gap_max = phase * 4;
            rx_stalls  = (phase != 0);
            live_frame = $urandom;
            live_count = 16'($urandom_range(1, 4));
            stop_at    = bytes_sent + 60;
            while (bytes_sent < stop_at) begin
                if ($urandom_range(0, 5) == 0) begin
                    live_frame = $urandom;
                    live_count = ($urandom_range(0, 9) == 0) ? 16'(MAX_CHUNKS_DEF)
                                                             : 16'($urandom_range(1, 4));
                end
                idx = 16'($urandom_range(0, live_count - 1));
                // steer towards a missing chunk half the time so frames complete
                if (cur_frame == live_frame && $urandom_range(0, 1)) begin
                    for (int i = live_count - 1; i >= 0; i--)
                        if (!got_map[i])
                            idx = 16'(i);
                end
                size = $urandom_range(0, 6);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_chunk(magic_reg, live_frame, idx, live_count, size,
                               size + $urandom_range(0, 2));
                else if (pick < 74)
                    send_chunk(magic_reg ^ (32'h1 << $urandom_range(0, 31)), live_frame,
                               idx, live_count, size, size);
                else if (pick < 78)
                    send_chunk(magic_reg, live_frame, idx, live_count, size + 1, size);
                else if (pick < 82)
                    send_chunk(magic_reg, live_frame, idx,
                               16'($urandom_range(MAX_CHUNKS_DEF + 1, 16'hFFFF)), size, size);
                else if (pick < 86)
                    send_chunk(magic_reg, live_frame,
                               16'($urandom_range(live_count, 16'hFFFF)), live_count, size, size);
                else if (pick < 93)
                    send_noise($urandom_range(1, HDR_LEN - 1));
                else
                    send_noise($urandom_range(1, 40));
            end
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_header_checks();
        test_frame_tracking();
        test_long_datagram();
        test_back_pressure();
        test_random_stream();

        drain_results();
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dcr_pkg.sv
rtl/core/dcr_ram.sv
rtl/core/dcr_fifo.sv
rtl/core/dcr_front.sv
rtl/core/dcr_back.sv
rtl/core/datagram_chunk_reassembler.sv
test/tb.sv
